[sv/acu_pkg.sv]
package acu_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_UNDO  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIV_REF  = 3'd1,
        ST_UNDO_MT  = 3'd2,
        ST_FULL     = 3'd3,
        ST_BAD_OP   = 3'd4,
        ST_SAT      = 3'd5
    } t_status;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

endpackage

[sv/acu_ram.sv]
module acu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/acu_muldiv.sv]
module acu_muldiv
    import acu_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_div,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_mag
);

    localparam int CW = 7;

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic         r_div, n_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [127:0] r_acc, n_acc;
    logic [127:0] r_num, n_num;
    logic [64:0]  r_rem, n_rem;
    logic [63:0]  r_b, n_b;
    logic [64:0]  rem_sh;
    logic [127:0] a_wide;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_num  = r_num;
        n_rem  = r_rem;
        n_b    = r_b;
        rem_sh = {r_rem[63:0], r_num[127]};
        a_wide = {64'd0, i_a};
        if (i_start) begin
            n_busy = 1'b1;
            n_div  = i_div;
            n_cnt  = '0;
            n_acc  = '0;
            n_rem  = '0;
            n_b    = i_b;
            n_num  = i_div ? (a_wide << FRACTION_BITS) : a_wide;
        end else if (r_busy) begin
            if (r_div) begin
                n_num = {r_num[126:0], 1'b0};
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = rem_sh - {1'b0, r_b};
                    n_acc = {r_acc[126:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_acc = {r_acc[126:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(127)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                n_acc = r_acc + (r_b[0] ? r_num : 128'd0);
                n_num = {r_num[126:0], 1'b0};
                n_b   = {1'b0, r_b[63:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(63)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_num <= n_num;
        r_rem <= n_rem;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_mag  = r_div ? r_acc : (r_acc >> FRACTION_BITS);

endmodule

[sv/accumulator_calc_with_undo_unit.sv]
// Channel | Direction | Signals
// in      | input     | i_in_valid, o_in_ready, i_operation, i_operand_value
// out     | output    | o_out_valid, i_out_ready, o_running_total, o_history_count,
//         |           | o_status_code
// One transaction at a time; ready is low from acceptance until the result is taken.
// Add, subtract and rejections go from execute to output; undo first passes the RAM
// read states; multiply: one shift-add per bit; divide: one quotient bit per cycle.
// Reset clears total and history count; the history RAM is not cleared.
// A stalled result holds the block; nothing new is accepted until it is taken.
module accumulator_calc_with_undo_unit
    import acu_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int FRACTION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic signed [63:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [63:0] o_running_total,
    output logic [6:0]  o_history_count,
    output logic [2:0]  o_status_code
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_RD    = 6'b001000,
        S_RD2   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [63:0]  r_total, n_total;
    logic [DW-1:0] r_depth, n_depth;
    logic [2:0]   r_op;
    logic [63:0]  r_b;
    logic         r_neg;
    logic [2:0]   r_status, n_status;

    logic         md_start, md_done;
    logic [127:0] md_mag;
    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]  ram_rdata;

    logic [63:0]  mag_a, mag_b, sum_b, sum_r;
    logic         sum_ovf;
    logic [63:0]  pk_lim;
    logic         pk_sat;
    logic [63:0]  pk_val;
    logic         accept;

    assign mag_a  = r_total[63] ? (64'd0 - r_total) : r_total;
    assign mag_b  = r_b[63] ? (64'd0 - r_b) : r_b;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        sum_b = (r_op == OP_SUB) ? (64'd0 - r_b) : r_b;
        sum_r = r_total + sum_b;
        sum_ovf = 1'b0;
        if (r_op == OP_SUB && r_b == NEG_MAG) begin
            sum_ovf = !r_total[63];
            sum_r   = r_total ^ NEG_MAG;
        end else if (r_total[63] == sum_b[63] && sum_r[63] != r_total[63]) begin
            sum_ovf = 1'b1;
        end
        if (sum_ovf) begin
            sum_r = r_total[63] ? NEG_MAG : POS_MAX;
        end
    end

    always_comb begin
        pk_lim = r_neg ? NEG_MAG : POS_MAX;
        pk_sat = (md_mag[127:64] != 64'd0) || (md_mag[63:0] > pk_lim);
        pk_val = pk_sat ? pk_lim : (r_neg ? (64'd0 - md_mag[63:0]) : md_mag[63:0]);
    end

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_depth  = r_depth;
        n_status = r_status;
        md_start = 1'b0;
        ram_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (r_op > OP_UNDO) begin
                    n_status = ST_BAD_OP;
                end else if (r_op == OP_UNDO) begin
                    if (r_depth == '0) begin
                        n_status = ST_UNDO_MT;
                    end else begin
                        n_depth  = r_depth - 1'b1;
                        n_status = ST_OK;
                        n_state  = S_RD;
                    end
                end else if (r_depth >= DW'(HISTORY_DEPTH)) begin
                    n_status = ST_FULL;
                end else if (r_op == OP_DIV && !r_b[63]
                             && (r_b >> FRACTION_BITS) == 64'd0) begin
                    n_status = ST_DIV_REF;
                end else begin
                    ram_we  = 1'b1;
                    n_depth = r_depth + 1'b1;
                    if (r_op == OP_ADD || r_op == OP_SUB) begin
                        n_total  = sum_r;
                        n_status = sum_ovf ? ST_SAT : ST_OK;
                    end else begin
                        md_start = 1'b1;
                        n_state  = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (md_done) begin
                    n_total  = pk_val;
                    n_status = pk_sat ? ST_SAT : ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_RD: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_total = ram_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_depth <= n_depth;
        end
        r_status <= n_status;
        if (accept) begin
            r_op  <= i_operation;
            r_b   <= i_operand_value;
        end
        if (r_state == S_EXEC) begin
            r_neg <= r_total[63] ^ r_b[63];
        end
    end

    assign ram_waddr = r_depth[AW-1:0];
    assign ram_raddr = r_depth[AW-1:0];

    acu_ram #(
        .WIDTH (64),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_total),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    acu_muldiv #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_div   (r_op == OP_DIV),
        .i_a     (mag_a),
        .i_b     (mag_b),
        .o_done  (md_done),
        .o_mag   (md_mag)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_running_total = r_total;
    assign o_history_count = 7'(r_depth);
    assign o_status_code   = r_status;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(HISTORY_DEPTH))
        else $error("history depth exceeds capacity");

    a_wait_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_start |=> (r_state == S_WAIT))
        else $error("unit started outside execute");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_WAIT))
        else $error("unit result with no waiting transaction");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_depth == $past(r_depth) + 1'b1))
        else $error("push without depth advance");

endmodule
